FILE: hw/rtl/pir_pkg.sv
`timescale 1ns / 1ps
// Shared types, register map codes and sizes for the priority interrupt router.
// Used by pir_regfile, pir_arbiter and priority_interrupt_router.
package pir_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned LINE_W    = 6;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned IRQ_W     = 6;
  localparam int unsigned LANE_W    = 3;
  localparam int unsigned SEL_W     = ADDR_W - LANE_W;
  localparam int unsigned BYTES     = DATA_W / 8;

  // Priority and map banks
  localparam int unsigned REG_WORDS = 6;
  localparam int unsigned REG_IDX_W = 3;

  // Parameter defaults
  localparam int unsigned INPUT_LINES_DEF  = 48;
  localparam int unsigned OUTPUT_LINES_DEF = 6;

  // Register selector (address bits 7..3)
  localparam logic [SEL_W-1:0] REG_MASK       = 5'd0;
  localparam logic [SEL_W-1:0] REG_VECTOR     = 5'd1;
  localparam logic [SEL_W-1:0] REG_PRIO_FIRST = 5'd2;
  localparam logic [SEL_W-1:0] REG_PRIO_LAST  = 5'd7;
  localparam logic [SEL_W-1:0] REG_MAP_FIRST  = 5'd10;
  localparam logic [SEL_W-1:0] REG_MAP_LAST   = 5'd15;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_LINE  = 2'd2,
    ACT_NONE  = 2'd3
  } pir_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FINISH
  } pir_state_e;

  // Per-line lookup handed from the register file to the arbiter
  typedef struct packed {
    logic              active;  // level high and unmasked
    logic [PRIO_W-1:0] prio;
    logic [IRQ_W-1:0]  route;   // low bits of the map byte
  } pir_line_t;

  // Scan result handed from the arbiter to the register file
  typedef struct packed {
    logic [IRQ_W-1:0]             hit;
    logic [IRQ_W-1:0][PRIO_W-1:0] vec;
  } pir_eval_t;

endpackage

FILE: hw/rtl/pir_regfile.sv
`timescale 1ns / 1ps
// Register file of the priority interrupt router: mask, vector, priority and
// map registers, input and output levels, byte-lane bus access. Uses pir_pkg.
module pir_regfile #(
  parameter int unsigned INPUT_LINES  = pir_pkg::INPUT_LINES_DEF,
  parameter int unsigned OUTPUT_LINES = pir_pkg::OUTPUT_LINES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              acc_i,
  input  logic [1:0]                        action_i,
  input  logic [pir_pkg::ADDR_W-1:0]        address_i,
  input  logic [pir_pkg::SIZE_W-1:0]        size_bytes_i,
  input  logic [pir_pkg::DATA_W-1:0]        write_data_i,
  input  logic [pir_pkg::LINE_W-1:0]        line_index_i,
  input  logic                              line_level_i,
  output logic [pir_pkg::DATA_W-1:0]        rd_data_o,
  output logic                              eval_req_o,
  input  logic [$clog2(INPUT_LINES)-1:0]    scan_idx_i,
  output pir_pkg::pir_line_t                line_o,
  input  logic                              commit_i,
  input  pir_pkg::pir_eval_t                eval_i,
  output logic [OUTPUT_LINES-1:0]           irq_o
);

  logic [pir_pkg::DATA_W-1:0] mask_q, mask_d;
  logic [pir_pkg::DATA_W-1:0] vector_q, vector_d;
  logic [pir_pkg::DATA_W-1:0] prio_q [pir_pkg::REG_WORDS];
  logic [pir_pkg::DATA_W-1:0] prio_d [pir_pkg::REG_WORDS];
  logic [pir_pkg::DATA_W-1:0] map_q  [pir_pkg::REG_WORDS];
  logic [pir_pkg::DATA_W-1:0] map_d  [pir_pkg::REG_WORDS];
  logic [INPUT_LINES-1:0]     levels_q, levels_d;
  logic [OUTPUT_LINES-1:0]    irq_q, irq_d;

  logic [pir_pkg::SEL_W-1:0]     reg_sel;
  logic [pir_pkg::LANE_W-1:0]    lane;
  logic [pir_pkg::REG_IDX_W-1:0] prio_idx, map_idx;
  logic                          is_prio, is_map;
  logic [pir_pkg::DATA_W-1:0]    sel_word, wr_shift, wr_mask, wr_word, rd_raw;
  logic [pir_pkg::BYTES-1:0]     byte_en;

  assign reg_sel  = address_i[pir_pkg::ADDR_W-1:pir_pkg::LANE_W];
  assign lane     = address_i[pir_pkg::LANE_W-1:0];
  assign is_prio  = reg_sel inside {[pir_pkg::REG_PRIO_FIRST:pir_pkg::REG_PRIO_LAST]};
  assign is_map   = reg_sel inside {[pir_pkg::REG_MAP_FIRST:pir_pkg::REG_MAP_LAST]};
  assign prio_idx = pir_pkg::REG_IDX_W'(reg_sel - pir_pkg::REG_PRIO_FIRST);
  assign map_idx  = pir_pkg::REG_IDX_W'(reg_sel - pir_pkg::REG_MAP_FIRST);

  // Selected register, zero when unmapped
  always_comb begin
    sel_word = '0;
    if (reg_sel == pir_pkg::REG_MASK) begin
      sel_word = mask_q;
    end else if (reg_sel == pir_pkg::REG_VECTOR) begin
      sel_word = vector_q;
    end else if (is_prio) begin
      sel_word = prio_q[prio_idx];
    end else if (is_map) begin
      sel_word = map_q[map_idx];
    end
  end

  // Byte enables: lanes from the start lane for size bytes, clipped at byte 7
  always_comb begin
    logic [pir_pkg::SIZE_W-1:0] ofs;
    for (int b = 0; b < pir_pkg::BYTES; b++) begin
      ofs        = pir_pkg::SIZE_W'(b) - {1'b0, lane};
      byte_en[b] = (pir_pkg::SIZE_W'(b) >= {1'b0, lane}) && (ofs < size_bytes_i);
      wr_mask[8*b +: 8] = {8{byte_en[b]}};
    end
  end

  assign wr_shift = write_data_i << {lane, 3'b000};
  assign wr_word  = (sel_word & ~wr_mask) | (wr_shift & wr_mask);

  // Read path: right-aligned, bytes beyond size read as zero
  assign rd_raw = sel_word >> {lane, 3'b000};
  always_comb begin
    rd_data_o = '0;
    if (action_i == pir_pkg::ACT_READ) begin
      for (int k = 0; k < pir_pkg::BYTES; k++) begin
        if (pir_pkg::SIZE_W'(k) < size_bytes_i) rd_data_o[8*k +: 8] = rd_raw[8*k +: 8];
      end
    end
  end

  // Evaluation follows every write, and a change on an unmasked valid line
  always_comb begin
    eval_req_o = 1'b0;
    if (action_i == pir_pkg::ACT_WRITE) begin
      eval_req_o = 1'b1;
    end else if (action_i == pir_pkg::ACT_LINE) begin
      eval_req_o = (32'(line_index_i) < INPUT_LINES) && !mask_q[line_index_i];
    end
  end

  // Next-state for bus writes, line changes and scan commits
  always_comb begin
    mask_d   = mask_q;
    vector_d = vector_q;
    prio_d   = prio_q;
    map_d    = map_q;
    levels_d = levels_q;
    irq_d    = irq_q;
    if (acc_i && action_i == pir_pkg::ACT_WRITE) begin
      if (reg_sel == pir_pkg::REG_MASK) begin
        mask_d = wr_word;
      end else if (is_prio) begin
        prio_d[prio_idx] = wr_word;
      end else if (is_map) begin
        map_d[map_idx] = wr_word;
      end
    end
    if (acc_i && action_i == pir_pkg::ACT_LINE) begin
      for (int i = 0; i < INPUT_LINES; i++) begin
        if (32'(line_index_i) == i) levels_d[i] = line_level_i;
      end
    end
    if (commit_i) begin
      for (int o = 0; o < OUTPUT_LINES; o++) begin
        if (eval_i.hit[o]) vector_d[8*o +: 8] = eval_i.vec[o];
        irq_d[o] = eval_i.hit[o];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      vector_q <= '0;
      levels_q <= '0;
      irq_q    <= '0;
      for (int w = 0; w < pir_pkg::REG_WORDS; w++) begin
        prio_q[w] <= '0;
        map_q[w]  <= '0;
      end
    end else begin
      mask_q   <= mask_d;
      vector_q <= vector_d;
      levels_q <= levels_d;
      irq_q    <= irq_d;
      prio_q   <= prio_d;
      map_q    <= map_d;
    end
  end

  // Lookup of the line under scan
  logic [pir_pkg::LINE_W-1:0]    scan_line;
  logic [pir_pkg::REG_IDX_W-1:0] scan_word;
  logic [pir_pkg::DATA_W-1:0]    prio_shift, map_shift;

  assign scan_line  = pir_pkg::LINE_W'(scan_idx_i);
  assign scan_word  = scan_line[pir_pkg::LINE_W-1:pir_pkg::LANE_W];
  assign prio_shift = prio_q[scan_word] >> {scan_line[pir_pkg::LANE_W-1:0], 3'b000};
  assign map_shift  = map_q[scan_word]  >> {scan_line[pir_pkg::LANE_W-1:0], 3'b000};

  assign line_o.active = levels_q[scan_idx_i] && !mask_q[scan_line];
  assign line_o.prio   = prio_shift[pir_pkg::PRIO_W-1:0];
  assign line_o.route  = map_shift[pir_pkg::IRQ_W-1:0];

  assign irq_o = irq_q;

endmodule

FILE: hw/rtl/pir_arbiter.sv
`timescale 1ns / 1ps
// Winner scan of the priority interrupt router: one line per cycle through a
// single priority comparator, best candidate kept per output. Uses pir_pkg.
module pir_arbiter #(
  parameter int unsigned INPUT_LINES  = pir_pkg::INPUT_LINES_DEF,
  parameter int unsigned OUTPUT_LINES = pir_pkg::OUTPUT_LINES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [$clog2(INPUT_LINES)-1:0] scan_idx_o,
  input  pir_pkg::pir_line_t             line_i,
  output pir_pkg::pir_eval_t             eval_o
);

  localparam int unsigned IDX_W = $clog2(INPUT_LINES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(INPUT_LINES - 1);

  logic                      running_q;
  logic [IDX_W-1:0]          idx_q;
  logic [OUTPUT_LINES-1:0]   has_q;
  logic [pir_pkg::LINE_W-1:0] win_q  [OUTPUT_LINES];
  logic [pir_pkg::PRIO_W-1:0] wprio_q [OUTPUT_LINES];

  logic [OUTPUT_LINES-1:0]    route, first_hot;
  logic                       cur_has, take;
  logic [pir_pkg::PRIO_W-1:0] cur_prio;

  // Lowest set route bit picks the output
  assign route     = line_i.route[OUTPUT_LINES-1:0];
  assign first_hot = route & (~route + OUTPUT_LINES'(1));

  // Shared comparator against the current best of that output
  always_comb begin
    cur_prio = '0;
    for (int o = 0; o < OUTPUT_LINES; o++) begin
      if (first_hot[o]) cur_prio = cur_prio | wprio_q[o];
    end
  end
  assign cur_has = |(first_hot & has_q);
  assign take    = running_q && line_i.active && (|route) &&
                   (!cur_has || (cur_prio < line_i.prio));

  assign done_o     = running_q && (idx_q == LAST_IDX);
  assign busy_o     = running_q;
  assign scan_idx_o = idx_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      idx_q     <= '0;
      has_q     <= '0;
    end else if (start_i) begin
      running_q <= 1'b1;
      idx_q     <= '0;
      has_q     <= '0;
    end else if (running_q) begin
      idx_q <= idx_q + IDX_W'(1);
      if (done_o) running_q <= 1'b0;
      if (take) has_q <= has_q | first_hot;
    end
  end

  // Best candidate per output
  always_ff @(posedge clk_i) begin
    for (int o = 0; o < OUTPUT_LINES; o++) begin
      if (take && first_hot[o]) begin
        win_q[o]   <= pir_pkg::LINE_W'(idx_q);
        wprio_q[o] <= line_i.prio;
      end
    end
  end

  always_comb begin
    eval_o = '0;
    for (int o = 0; o < OUTPUT_LINES; o++) begin
      eval_o.hit[o] = has_q[o];
      eval_o.vec[o] = pir_pkg::PRIO_W'(win_q[o]);
    end
  end

endmodule

FILE: hw/rtl/priority_interrupt_router.sv
`timescale 1ns / 1ps
// Top level of the priority interrupt router: transfer control, result register.
// Depends on pir_pkg, pir_regfile and pir_arbiter.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------
//   in      | to block  | in_valid_i / in_stall_o | action, address, size_bytes,
//           |           |                         | write_data, line_index, line_level
//   out     | from block| out_valid_o/ out_stall_i| read_data, irq_lines
//
// A read, a masked or out-of-range line change or an unused action goes from IDLE
// straight to FINISH; a write or an unmasked line change goes through SCAN, where the
// scan feeds one line per cycle to one comparator, and COMMIT before FINISH. The result
// is raised and the input freed together, when FINISH loads the output register.
// Reset clears control state and out_valid: no result is pending; data is not reset.
// A stalled result holds in the output register while the next item is already taken
// and worked on; it waits in FINISH only if the output is still occupied.
module priority_interrupt_router #(
  parameter int unsigned INPUT_LINES  = pir_pkg::INPUT_LINES_DEF,
  parameter int unsigned OUTPUT_LINES = pir_pkg::OUTPUT_LINES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [pir_pkg::ADDR_W-1:0] address_i,
  input  logic [pir_pkg::SIZE_W-1:0] size_bytes_i,
  input  logic [pir_pkg::DATA_W-1:0] write_data_i,
  input  logic [pir_pkg::LINE_W-1:0] line_index_i,
  input  logic                       line_level_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pir_pkg::DATA_W-1:0] read_data_o,
  output logic [pir_pkg::IRQ_W-1:0]  irq_lines_o
);

  localparam int unsigned IDX_W = $clog2(INPUT_LINES);

  pir_pkg::pir_state_e state_q, state_d;

  logic                       in_acc, eval_req, scan_start, scan_busy, scan_done, commit;
  logic                       out_load;
  logic [pir_pkg::DATA_W-1:0] rd_data, rd_stage_q;
  logic [IDX_W-1:0]           scan_idx;
  pir_pkg::pir_line_t         line_info;
  pir_pkg::pir_eval_t         eval_res;
  logic [OUTPUT_LINES-1:0]    irq_levels;
  logic                       out_valid_q;
  logic [pir_pkg::DATA_W-1:0] read_data_q;
  logic [pir_pkg::IRQ_W-1:0]  irq_lines_q;

  assign in_stall_o = (state_q != pir_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign scan_start = in_acc && eval_req;

  pir_regfile #(
    .INPUT_LINES (INPUT_LINES),
    .OUTPUT_LINES(OUTPUT_LINES)
  ) u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .action_i    (action_i),
    .address_i   (address_i),
    .size_bytes_i(size_bytes_i),
    .write_data_i(write_data_i),
    .line_index_i(line_index_i),
    .line_level_i(line_level_i),
    .rd_data_o   (rd_data),
    .eval_req_o  (eval_req),
    .scan_idx_i  (scan_idx),
    .line_o      (line_info),
    .commit_i    (commit),
    .eval_i      (eval_res),
    .irq_o       (irq_levels)
  );

  pir_arbiter #(
    .INPUT_LINES (INPUT_LINES),
    .OUTPUT_LINES(OUTPUT_LINES)
  ) u_arbiter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .busy_o    (scan_busy),
    .done_o    (scan_done),
    .scan_idx_o(scan_idx),
    .line_i    (line_info),
    .eval_o    (eval_res)
  );

  // Sequencer: next state and control strobes
  always_comb begin
    state_d  = state_q;
    commit   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      pir_pkg::ST_IDLE: begin
        if (in_acc) state_d = eval_req ? pir_pkg::ST_SCAN : pir_pkg::ST_FINISH;
      end
      pir_pkg::ST_SCAN: begin
        if (scan_done) state_d = pir_pkg::ST_COMMIT;
      end
      pir_pkg::ST_COMMIT: begin
        commit  = 1'b1;
        state_d = pir_pkg::ST_FINISH;
      end
      pir_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = pir_pkg::ST_IDLE;
        end
      end
      default: state_d = pir_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pir_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Read data staged at transfer
  always_ff @(posedge clk_i) begin
    if (in_acc) rd_stage_q <= rd_data;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      read_data_q <= rd_stage_q;
      irq_lines_q <= pir_pkg::IRQ_W'(irq_levels);
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign irq_lines_o = irq_lines_q;

  // Checks
  a_scan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_start |=> scan_busy && (state_q == pir_pkg::ST_SCAN))
    else $error("scan did not start after an evaluating transfer");

  a_scan_state_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pir_pkg::ST_SCAN) |-> scan_busy)
    else $error("SCAN state without a running scan");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == pir_pkg::ST_FINISH))
    else $error("result raised outside FINISH");

  a_irq_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((irq_lines_o >> OUTPUT_LINES) == '0))
    else $error("irq line above OUTPUT_LINES set");

  a_no_scan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pir_pkg::ST_IDLE) |-> !scan_busy)
    else $error("scan running while idle");

endmodule

FILE: sim/priority_interrupt_router_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for priority_interrupt_router: bus reads, writes and line changes
// are checked against an in-bench model of the register file, routing and arbitration.
// Depends on pir_pkg and the priority_interrupt_router RTL.
module priority_interrupt_router_tb;

  localparam int unsigned NUM_LINES   = 48;
  localparam int unsigned NUM_OUTS    = 6;
  localparam int unsigned RAND_ITEMS  = 1770;
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES = 60;

  // Register byte addresses
  localparam logic [pir_pkg::ADDR_W-1:0] A_MASK   = {pir_pkg::REG_MASK, 3'd0};
  localparam logic [pir_pkg::ADDR_W-1:0] A_VECTOR = {pir_pkg::REG_VECTOR, 3'd0};
  localparam logic [pir_pkg::ADDR_W-1:0] A_PRIO0  = {pir_pkg::REG_PRIO_FIRST, 3'd0};
  localparam logic [pir_pkg::ADDR_W-1:0] A_MAP0   = {pir_pkg::REG_MAP_FIRST, 3'd0};

  typedef struct {
    pir_pkg::pir_action_e       act;
    logic [pir_pkg::ADDR_W-1:0] addr;
    logic [pir_pkg::SIZE_W-1:0] size;
    logic [pir_pkg::DATA_W-1:0] data;
    logic [pir_pkg::LINE_W-1:0] line;
    logic                       level;
    bit                         hold_for_drain;  // wait until all results are back
  } bus_item_t;

  typedef struct {
    logic [pir_pkg::DATA_W-1:0] rdata;
    logic [pir_pkg::IRQ_W-1:0]  irq;
  } router_out_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Block ports
  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  logic [1:0]                 action     = '0;
  logic [pir_pkg::ADDR_W-1:0] address    = '0;
  logic [pir_pkg::SIZE_W-1:0] size_bytes = '0;
  logic [pir_pkg::DATA_W-1:0] write_data = '0;
  logic [pir_pkg::LINE_W-1:0] line_index = '0;
  logic                       line_level = 1'b0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  logic [pir_pkg::DATA_W-1:0] read_data;
  logic [pir_pkg::IRQ_W-1:0]  irq_lines;

  priority_interrupt_router u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .address_i    (address),
    .size_bytes_i (size_bytes),
    .write_data_i (write_data),
    .line_index_i (line_index),
    .line_level_i (line_level),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_o  (read_data),
    .irq_lines_o  (irq_lines)
  );

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  // Bookkeeping
  bus_item_t   bus_items[$];
  router_out_t expected_results[$];
  int unsigned n_total  = 0;
  int unsigned n_sent   = 0;
  int unsigned n_recv   = 0;
  int unsigned errors   = 0;
  int unsigned act_count[4];
  logic [pir_pkg::IRQ_W-1:0] irq_seen = '0;

  // Router state as the block should hold it
  logic [63:0]               mask_word = '0;
  logic [63:0]               vec_word  = '0;
  logic [63:0]               line_lvl  = '0;
  logic [63:0]               prio_word[pir_pkg::REG_WORDS];
  logic [63:0]               map_word[pir_pkg::REG_WORDS];
  logic [pir_pkg::IRQ_W-1:0] irq_lvl   = '0;

  initial begin
    for (int i = 0; i < pir_pkg::REG_WORDS; i++) begin
      prio_word[i] = '0;
      map_word[i]  = '0;
    end
    for (int i = 0; i < 4; i++) act_count[i] = 0;
  end

  function automatic logic [63:0] lane_mask(int unsigned nbytes);
    return (nbytes >= 8) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
  endfunction

  function automatic logic [7:0] prio_of(int unsigned n);
    return prio_word[n / 8][8 * (n % 8) +: 8];
  endfunction

  // Route every active unmasked line to its lowest mapped output, pick winners
  function automatic void rearbitrate();
    logic [NUM_OUTS-1:0]       has;
    int unsigned               win[NUM_OUTS];
    logic [pir_pkg::IRQ_W-1:0] route;
    int unsigned               o;
    has = '0;
    for (int k = 0; k < NUM_OUTS; k++) win[k] = 0;
    for (int n = 0; n < NUM_LINES; n++) begin
      if (line_lvl[n] && !mask_word[n]) begin
        route = map_word[n / 8][8 * (n % 8) +: pir_pkg::IRQ_W];
        if (route != '0) begin
          o = 0;
          while (!route[o]) o++;
          if (!has[o]) begin
            has[o] = 1'b1;
            win[o] = n;
          end else if (prio_of(win[o]) < prio_of(n)) begin
            win[o] = n;
          end
        end
      end
    end
    irq_lvl = '0;
    for (int k = 0; k < NUM_OUTS; k++) begin
      if (has[k]) begin
        vec_word[8 * k +: 8] = 8'(win[k]);
        irq_lvl[k] = 1'b1;
      end
    end
  endfunction

  // Apply one transfer to the state and return the result it should produce
  function automatic router_out_t router_step(bus_item_t it);
    router_out_t               res;
    logic [pir_pkg::SEL_W-1:0] sel;
    int unsigned               lane;
    int unsigned               nbytes;
    logic [63:0]               cur;
    logic [63:0]               m;
    bit                        mapped;
    bit                        writable;
    sel       = it.addr[pir_pkg::ADDR_W-1:pir_pkg::LANE_W];
    lane      = it.addr[pir_pkg::LANE_W-1:0];
    nbytes    = (it.size > 8 - lane) ? 8 - lane : it.size;
    res.rdata = '0;
    mapped    = 1'b1;
    writable  = 1'b1;
    cur       = '0;
    if (sel == pir_pkg::REG_MASK) cur = mask_word;
    else if (sel == pir_pkg::REG_VECTOR) begin
      cur = vec_word;
      writable = 1'b0;
    end else if (sel >= pir_pkg::REG_PRIO_FIRST && sel <= pir_pkg::REG_PRIO_LAST)
      cur = prio_word[sel - pir_pkg::REG_PRIO_FIRST];
    else if (sel >= pir_pkg::REG_MAP_FIRST && sel <= pir_pkg::REG_MAP_LAST)
      cur = map_word[sel - pir_pkg::REG_MAP_FIRST];
    else mapped = 1'b0;

    case (it.act)
      pir_pkg::ACT_READ: begin
        if (mapped) res.rdata = (cur >> (8 * lane)) & lane_mask(nbytes);
      end
      pir_pkg::ACT_WRITE: begin
        if (mapped && writable) begin
          m   = lane_mask(nbytes) << (8 * lane);
          cur = (cur & ~m) | ((it.data << (8 * lane)) & m);
          if (sel == pir_pkg::REG_MASK) mask_word = cur;
          else if (sel <= pir_pkg::REG_PRIO_LAST) prio_word[sel - pir_pkg::REG_PRIO_FIRST] = cur;
          else map_word[sel - pir_pkg::REG_MAP_FIRST] = cur;
        end
        // every write re-evaluates, even an ignored one
        rearbitrate();
      end
      pir_pkg::ACT_LINE: begin
        if (it.line < NUM_LINES) begin
          line_lvl[it.line] = it.level;
          if (!mask_word[it.line]) rearbitrate();
        end
      end
      default: ;
    endcase
    res.irq = irq_lvl;
    return res;
  endfunction

  // Idle mix: sender light / receiver heavy, then swapped, then none
  function automatic int unsigned run_phase();
    if (n_sent < n_total / 3) return 0;
    if (n_sent < (2 * n_total) / 3) return 1;
    return 2;
  endfunction

  function automatic int unsigned sender_idle_pct();
    case (run_phase())
      0:       return 12;
      1:       return 69;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_idle_pct();
    case (run_phase())
      0:       return 69;
      1:       return 12;
      default: return 0;
    endcase
  endfunction

  function automatic bus_item_t mk(pir_pkg::pir_action_e a, logic [pir_pkg::ADDR_W-1:0] ad,
                                   logic [pir_pkg::SIZE_W-1:0] sz,
                                   logic [pir_pkg::DATA_W-1:0] d,
                                   logic [pir_pkg::LINE_W-1:0] ln, logic lv);
    bus_item_t it;
    it.act   = a;
    it.addr  = ad;
    it.size  = sz;
    it.data  = d;
    it.line  = ln;
    it.level = lv;
    it.hold_for_drain = 1'b0;
    return it;
  endfunction

  // Map bytes mostly route somewhere, with random bits above the routing bit
  function automatic logic [63:0] rand_map_word();
    logic [63:0] w;
    logic [7:0]  low;
    for (int i = 0; i < 8; i++) begin
      low = 8'h01 << $urandom_range(0, pir_pkg::IRQ_W - 1);
      w[8 * i +: 8] = low | (8'($urandom) & ~((low << 1) - 8'h01));
      if ($urandom_range(0, 9) == 0) w[8 * i +: 8] = 8'($urandom_range(0, 3)) << pir_pkg::IRQ_W;
    end
    return w;
  endfunction

  // Narrow priorities half the time so ties are common
  function automatic logic [63:0] rand_prio_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++)
      w[8 * i +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    return w;
  endfunction

  // Stimulus, reset and end of run
  initial begin
    bus_item_t                  it;
    int unsigned                useful;
    int unsigned                pick;
    logic [2:0]                 lane;
    logic [pir_pkg::DATA_W-1:0] rnd;

    // Directed: reset values, routing, ties, masking, odd addresses and sizes
    bus_items.push_back(mk(pir_pkg::ACT_READ,  A_MASK,   4'd8, '0, '0, 1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_READ,  A_VECTOR, 4'd8, '0, '0, 1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_WRITE, A_MAP0,   4'd8, 64'h2010_C008_0401_0300, '0,
                           1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_LINE,  '0, '0, '0, 6'd1, 1'b1));
    bus_items.push_back(mk(pir_pkg::ACT_LINE,  '0, '0, '0, 6'd2, 1'b1));  // tie, lower index
    bus_items.push_back(mk(pir_pkg::ACT_WRITE, A_PRIO0,  4'd8, 64'hFF00_0000_0080_7F00, '0,
                           1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_READ,  A_VECTOR, 4'd1, '0, '0, 1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_WRITE, A_VECTOR, 4'd8, '1, '0, 1'b0));  // read-only
    bus_items.push_back(mk(pir_pkg::ACT_READ,  A_VECTOR, 4'd8, '0, '0, 1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_WRITE, A_MASK,   4'd1, 64'h04, '0, 1'b0));
    // masked line, no re-evaluation
    bus_items.push_back(mk(pir_pkg::ACT_LINE,  '0, '0, '0, 6'd2, 1'b0));
    // map byte above the outputs
    bus_items.push_back(mk(pir_pkg::ACT_LINE,  '0, '0, '0, 6'd5, 1'b1));
    bus_items.push_back(mk(pir_pkg::ACT_LINE,  '0, '0, '0, 6'd0, 1'b1));  // map byte zero
    bus_items.push_back(mk(pir_pkg::ACT_WRITE, {pir_pkg::REG_MAP_LAST, 3'd7}, 4'd1, 64'h20,
                           '0, 1'b0));
    // past the end of the register
    bus_items.push_back(mk(pir_pkg::ACT_WRITE, {pir_pkg::REG_PRIO_LAST, 3'd7}, 4'd8, '1,
                           '0, 1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_LINE,  '0, '0, '0, 6'd47, 1'b1));
    bus_items.push_back(mk(pir_pkg::ACT_LINE,  '0, '0, '0, 6'd48, 1'b1));  // line out of range
    bus_items.push_back(mk(pir_pkg::ACT_LINE,  '0, '0, '0, 6'd63, 1'b1));
    bus_items.push_back(mk(pir_pkg::ACT_READ,  8'h40, 4'd8, '0, '0, 1'b0));  // unmapped gap
    bus_items.push_back(mk(pir_pkg::ACT_READ,  8'hFF, 4'd15, '0, '0, 1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_WRITE, 8'h48, 4'd8, '1, '0, 1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_READ,  {pir_pkg::REG_PRIO_LAST, 3'd5}, 4'd15, '0,
                           '0, 1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_WRITE, A_MASK, 4'd0, '1, '0, 1'b0));  // zero size
    bus_items.push_back(mk(pir_pkg::ACT_READ,  A_MASK, 4'd0, '0, '0, 1'b0));
    bus_items.push_back(mk(pir_pkg::ACT_NONE,  A_MAP0, 4'd8, '1, 6'd1, 1'b0));
    it = mk(pir_pkg::ACT_READ, A_MASK, 4'd8, '0, '0, 1'b0);
    it.hold_for_drain = 1'b1;
    bus_items.push_back(it);

    // Random: mostly register setup, reads and line changes, some raw noise
    useful = 0;
    while (useful < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      lane = 3'($urandom_range(0, 7));
      rnd  = {$urandom, $urandom};
      it   = mk(pir_pkg::ACT_LINE, '0, '0, rnd, 6'($urandom_range(0, NUM_LINES - 1)),
                1'($urandom_range(0, 1)));
      if (pick < 10) begin
        it = mk(pir_pkg::pir_action_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                4'($urandom_range(0, 15)), rnd, 6'($urandom_range(0, 63)),
                1'($urandom_range(0, 1)));
      end else if (pick < 18) begin
        it.act  = pir_pkg::ACT_WRITE;
        it.addr = {pir_pkg::REG_MAP_FIRST +
                   pir_pkg::SEL_W'($urandom_range(0, pir_pkg::REG_WORDS - 1)), 3'd0};
        it.size = 4'd8;
        it.data = rand_map_word();
      end else if (pick < 24) begin
        it.act  = pir_pkg::ACT_WRITE;
        it.addr = {pir_pkg::REG_PRIO_FIRST +
                   pir_pkg::SEL_W'($urandom_range(0, pir_pkg::REG_WORDS - 1)), 3'd0};
        it.size = 4'd8;
        it.data = rand_prio_word();
      end else if (pick < 28) begin
        it.act  = pir_pkg::ACT_WRITE;
        it.addr = A_MASK;
        it.size = 4'd8;
        it.data = $urandom_range(0, 3) == 0 ? '0
                  : rnd & {$urandom, $urandom} & {$urandom, $urandom};
      end else if (pick < 34) begin
        it.act  = pir_pkg::ACT_WRITE;
        it.addr = {pir_pkg::SEL_W'($urandom_range(0, 15)), lane};
        it.size = 4'($urandom_range(1, 8));
      end else if (pick < 50) begin
        it.act  = pir_pkg::ACT_READ;
        it.addr = {pir_pkg::SEL_W'($urandom_range(0, 15)), lane};
        it.size = 4'($urandom_range(1, 8));
      end
      it.hold_for_drain = ($urandom_range(0, 199) == 0);
      if (it.act != pir_pkg::ACT_NONE && !(it.act == pir_pkg::ACT_LINE && it.line >= NUM_LINES))
        useful++;
      bus_items.push_back(it);
    end
    n_total = bus_items.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bus_items.size() != 0 || n_sent != n_recv) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d transfers: %0d reads, %0d writes, %0d line changes, %0d unused.",
             n_sent, act_count[pir_pkg::ACT_READ], act_count[pir_pkg::ACT_WRITE],
             act_count[pir_pkg::ACT_LINE], act_count[pir_pkg::ACT_NONE]);
    $display("Output lines seen raised: %b; mismatches: %0d.", irq_seen, errors);
    if (errors == 0) begin
      $display("PASS priority_interrupt_router");
    end else begin
      $display("FAIL priority_interrupt_router");
    end
    $finish;
  end

  // Driver: present the head of the item queue, hold it until transferred
  always @(posedge clk_i) begin : drive
    bus_item_t   cur;
    int unsigned outstanding;
    if (rst_ni) begin
      if (in_fire) begin
        cur = bus_items.pop_front();
        expected_results.push_back(router_step(cur));
        act_count[cur.act]++;
        n_sent <= n_sent + 1;
      end
      if (!in_valid || in_fire) begin
        outstanding = n_sent + (in_fire ? 1 : 0) - n_recv - (out_fire ? 1 : 0);
        if (bus_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct() &&
            (!bus_items[0].hold_for_drain || outstanding == 0)) begin
          in_valid   <= 1'b1;
          action     <= bus_items[0].act;
          address    <= bus_items[0].addr;
          size_bytes <= bus_items[0].size;
          write_data <= bus_items[0].data;
          line_index <= bus_items[0].line;
          line_level <= bus_items[0].level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : collect
    router_out_t want;
    if (rst_ni) begin
      if (out_fire) begin
        if (n_sent == n_recv) begin
          errors++;
          $display("%0t: unexpected result: read_data %h irq_lines %b", $time, read_data,
                   irq_lines);
        end else begin
          want = expected_results.pop_front();
          n_recv <= n_recv + 1;
          irq_seen = irq_seen | irq_lines;
          if (read_data !== want.rdata) begin
            errors++;
            $display("%0t: read_data mismatch: expected %h, actual %h", $time, want.rdata,
                     read_data);
          end
          if (irq_lines !== want.irq) begin
            errors++;
            $display("%0t: irq_lines mismatch: expected %b, actual %b", $time, want.irq,
                     irq_lines);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (in_fire || out_fire) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL priority_interrupt_router");
      $finish;
    end
  end

endmodule
